@@ rtl/core/ssbsc_pkg.sv @@
package ssbsc_pkg;

	// sample and accumulator formats
	localparam int SAMPLE_BITS = 24;
	localparam int ACC_BITS    = 32;
	localparam int FRAC        = ACC_BITS - 4;
	localparam int SFRAC       = SAMPLE_BITS - 1;
	localparam int IN_SHIFT    = FRAC - SFRAC;

	// coefficient math, Q0.16
	localparam int Q16        = 16;
	localparam int ONE16      = 65536;
	localparam int THIRD16    = 21845;
	localparam int TWOTHIRD16 = 43691;
	localparam int MAG_SHIFT  = FRAC - Q16;
	localparam int MAG_W      = FRAC + 2 - MAG_SHIFT;
	localparam int OFF_W      = Q16 + 1;
	localparam int OFFR_W     = OFF_W + 3;

	// register widths
	localparam int COEF_W     = 16;
	localparam int STEP_W     = 23;
	localparam int LIM_SHIFT  = FRAC - STEP_W;
	localparam int LIM_W      = STEP_W + LIM_SHIFT;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = STEP_W;

	// shared multiplier
	localparam int MUL_A_W = ACC_BITS + 1;
	localparam int MUL_B_W = OFF_W + 1;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// datapath widths
	localparam int H_W = ACC_BITS + 1;
	localparam int D_W = ACC_BITS + 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TREBLE_COEF  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASS_COEF    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TREBLE_LIMIT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BASS_LIMIT   = 2'd3;

	// register reset values
	localparam logic [COEF_W-1:0] RST_TREBLE_COEF  = 16'd37683;
	localparam logic [COEF_W-1:0] RST_BASS_COEF    = 16'd11165;
	localparam logic [STEP_W-1:0] RST_TREBLE_LIMIT = 23'd67948;
	localparam logic [STEP_W-1:0] RST_BASS_LIMIT   = 23'd214748;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_in;
		logic signed [SAMPLE_BITS-1:0] right_in;
	} smp_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_out;
		logic signed [SAMPLE_BITS-1:0] right_out;
	} res_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_OFF_T,
		MUL_MAG_B,
		MUL_K,
		MUL_DIFF
	} mul_op_t;

	// sequencer to datapath
	typedef struct packed {
		logic    accept;
		logic    from_port;
		logic    ch;
		logic    bass;
		mul_op_t mul_op;
		logic    wr_acc;
		logic    slew_en;
		logic    slew_bass;
		logic    fin_left;
		logic    fin_right;
		logic    hold_right;
		logic    push_hold;
	} ctl_t;

endpackage

@@ rtl/core/ssbsc_mul.sv @@
module ssbsc_mul
	import ssbsc_pkg::*;
(
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [PROD_W-1:0]  p
);

	logic signed [PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= PROD_W'(a) * PROD_W'(b);
		end
	end

	assign p = p_q;

endmodule

@@ rtl/core/ssbsc_seq.sv @@
module ssbsc_seq
	import ssbsc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic smp_valid,
	input  logic out_free,
	output logic smp_ready,
	output ctl_t ctl
);

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_TOFF  = 10'b0000000010,
		ST_TK    = 10'b0000000100,
		ST_TDIFF = 10'b0000001000,
		ST_TACC  = 10'b0000010000,
		ST_BK    = 10'b0000100000,
		ST_BDIFF = 10'b0001000000,
		ST_BACC  = 10'b0010000000,
		ST_BSLEW = 10'b0100000000,
		ST_WAIT  = 10'b1000000000
	} st_t;

	st_t  st_q, st_d;
	logic ch_q, ch_d;

	always_comb begin
		st_d      = st_q;
		ch_d      = ch_q;
		smp_ready = 1'b0;
		ctl       = '0;
		ctl.ch    = ch_q;
		ctl.mul_op = MUL_NONE;
		unique case (st_q)
			ST_IDLE: begin
				smp_ready = 1'b1;
				if (smp_valid) begin
					ctl.accept    = 1'b1;
					ctl.from_port = 1'b1;
					ctl.ch        = 1'b0;
					ctl.mul_op    = MUL_OFF_T;
					ch_d          = 1'b0;
					st_d          = ST_TK;
				end
			end
			ST_TOFF: begin
				ctl.mul_op = MUL_OFF_T;
				st_d       = ST_TK;
			end
			ST_TK: begin
				ctl.mul_op = MUL_K;
				st_d       = ST_TDIFF;
			end
			ST_TDIFF: begin
				ctl.mul_op = MUL_DIFF;
				st_d       = ST_TACC;
			end
			ST_TACC: begin
				ctl.wr_acc = 1'b1;
				ctl.mul_op = MUL_MAG_B;
				st_d       = ST_BK;
			end
			ST_BK: begin
				ctl.bass   = 1'b1;
				ctl.mul_op = MUL_K;
				st_d       = ST_BDIFF;
			end
			ST_BDIFF: begin
				ctl.bass    = 1'b1;
				ctl.mul_op  = MUL_DIFF;
				ctl.slew_en = 1'b1;
				st_d        = ST_BACC;
			end
			ST_BACC: begin
				ctl.bass   = 1'b1;
				ctl.wr_acc = 1'b1;
				st_d       = ST_BSLEW;
			end
			ST_BSLEW: begin
				ctl.slew_en   = 1'b1;
				ctl.slew_bass = 1'b1;
				if (!ch_q) begin
					ctl.fin_left = 1'b1;
					ch_d         = 1'b1;
					st_d         = ST_TOFF;
				end else if (out_free) begin
					ctl.fin_right = 1'b1;
					ch_d          = 1'b0;
					st_d          = ST_IDLE;
				end else begin
					ctl.hold_right = 1'b1;
					ch_d           = 1'b0;
					st_d           = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (out_free) begin
					ctl.push_hold = 1'b1;
					st_d          = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
				ch_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ch_q <= 1'b0;
		end else begin
			st_q <= st_d;
			ch_q <= ch_d;
		end
	end

endmodule

@@ rtl/core/stereo_split_band_slew_conditioner.sv @@
// Channel  Direction  Handshake               Payload
// smp      in         smp_valid / smp_ready   smp_t: left_in, right_in (Q1.23)
// res      out        res_valid / res_ready   res_t: left_out, right_out (Q1.23)
// cfg      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Each stereo beat runs eight sequencer steps per channel, each
// step issuing at most one product on the shared signed multiplier.
// The next beat is taken as soon as the sequencer is back in idle; a result
// waiting in the output register only holds the block if the next result is
// finished before it is taken.
// Reset clears filter and slew state, selects bank A and loads register
// defaults. cfg is always ready; write it only while idle.
module stereo_split_band_slew_conditioner
	import ssbsc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  smp_valid,
	output logic                  smp_ready,
	input  smp_t                  smp,
	output logic                  res_valid,
	input  logic                  res_ready,
	output res_t                  res,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// saturate to the accumulator width
	function automatic logic signed [ACC_BITS-1:0] sat_acc(input logic signed [D_W-1:0] v);
		logic signed [D_W-1:0] hi;
		logic signed [D_W-1:0] lo;
		hi = {3'b000, {(ACC_BITS-1){1'b1}}};
		lo = {3'b111, {(ACC_BITS-1){1'b0}}};
		if (v > hi) begin
			return hi[ACC_BITS-1:0];
		end else if (v < lo) begin
			return lo[ACC_BITS-1:0];
		end
		return v[ACC_BITS-1:0];
	endfunction

	// saturate to the sample width
	function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(input logic signed [D_W-1:0] v);
		logic signed [D_W-1:0] hi;
		logic signed [D_W-1:0] lo;
		hi = {{(D_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
		lo = {{(D_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
		if (v > hi) begin
			return hi[SAMPLE_BITS-1:0];
		end else if (v < lo) begin
			return lo[SAMPLE_BITS-1:0];
		end
		return v[SAMPLE_BITS-1:0];
	endfunction

	ctl_t ctl;
	logic out_free;

	// configuration
	logic [COEF_W-1:0] treble_coef_q, bass_coef_q;
	logic [STEP_W-1:0] treble_lim_q, bass_lim_q;

	// filter and slew state; acc index is {channel, bank}
	logic signed [ACC_BITS-1:0] acc_t_q [4];
	logic signed [ACC_BITS-1:0] acc_b_q [4];
	logic signed [ACC_BITS-1:0] prev_t_q [2];
	logic signed [ACC_BITS-1:0] prev_b_q [2];
	logic                       bank_q;

	// per-beat working registers
	smp_t                          smp_q;
	logic signed [H_W-1:0]         h_t_q, h_b_q;
	logic signed [SAMPLE_BITS-1:0] left_res_q, right_res_q;
	res_t                          res_q;
	logic                          res_valid_q;

	ssbsc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp_valid),
		.out_free  (out_free),
		.smp_ready (smp_ready),
		.ctl       (ctl)
	);

	assign out_free  = !res_valid_q || res_ready;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// ------------------------------------------------------------------
	// operand select
	// ------------------------------------------------------------------
	logic signed [SAMPLE_BITS-1:0] cur_smp;
	logic signed [ACC_BITS-1:0]    x_v, t_v, sel_v, acc_sel;
	logic [ACC_BITS-1:0]           abs_t, abs_x;
	logic [MAG_W-1:0]              mag_t, mag_x;
	logic [1:0]                    idx;

	always_comb begin
		if (ctl.from_port) begin
			cur_smp = smp.left_in;
		end else if (ctl.ch) begin
			cur_smp = smp_q.right_in;
		end else begin
			cur_smp = smp_q.left_in;
		end
	end

	// Q1.23 -> Q4.28; treble path is the sample doubled
	assign x_v   = {{(ACC_BITS-SAMPLE_BITS-IN_SHIFT){cur_smp[SAMPLE_BITS-1]}},
			cur_smp, {IN_SHIFT{1'b0}}};
	assign t_v   = x_v <<< 1;
	assign sel_v = ctl.bass ? x_v : t_v;

	assign abs_t = t_v[ACC_BITS-1] ? ACC_BITS'(-t_v) : ACC_BITS'(t_v);
	assign abs_x = x_v[ACC_BITS-1] ? ACC_BITS'(-x_v) : ACC_BITS'(x_v);
	assign mag_t = abs_t[MAG_SHIFT +: MAG_W];
	assign mag_x = abs_x[MAG_SHIFT +: MAG_W];

	// bank_q high means bank A (index 0)
	assign idx     = {ctl.ch, ~bank_q};
	assign acc_sel = ctl.bass ? acc_b_q[idx] : acc_t_q[idx];

	// ------------------------------------------------------------------
	// shared multiplier and its post-processing
	// ------------------------------------------------------------------
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic signed [PROD_W-1:0]  psh;
	logic signed [MAG_W:0]     toff_a;
	logic signed [OFFR_W-1:0]  off_raw;
	logic [OFF_W-1:0]          off_v;
	logic [COEF_W-1:0]         k_v;
	logic signed [H_W-1:0]     diff_v;
	logic signed [D_W-1:0]     acc_sum;
	logic signed [ACC_BITS-1:0] acc_new;
	logic signed [H_W-1:0]     h_new;

	assign psh = prod >>> Q16;

	// level-dependent offset, clamped to 0..1
	always_comb begin
		if (ctl.bass) begin
			off_raw = OFFR_W'(THIRD16) + signed'(psh[OFFR_W-1:0]);
		end else begin
			off_raw = OFFR_W'(ONE16 - THIRD16) - signed'(psh[OFFR_W-1:0]);
		end
		if (off_raw < 0) begin
			off_v = '0;
		end else if (off_raw > OFFR_W'(ONE16)) begin
			off_v = OFF_W'(ONE16);
		end else begin
			off_v = off_raw[OFF_W-1:0];
		end
	end

	assign toff_a = (MAG_W+1)'(ONE16) - signed'({1'b0, mag_t});
	assign k_v    = prod[Q16 +: COEF_W];
	assign diff_v = H_W'(sel_v) - H_W'(acc_sel);

	always_comb begin
		case (ctl.mul_op)
			MUL_OFF_T: begin
				mul_a = MUL_A_W'(toff_a);
				mul_b = MUL_B_W'(THIRD16);
			end
			MUL_MAG_B: begin
				mul_a = signed'(MUL_A_W'(mag_x));
				mul_b = MUL_B_W'(TWOTHIRD16);
			end
			MUL_K: begin
				mul_a = signed'(MUL_A_W'(off_v));
				mul_b = signed'(MUL_B_W'(ctl.bass ? bass_coef_q : treble_coef_q));
			end
			MUL_DIFF: begin
				mul_a = diff_v;
				mul_b = signed'(MUL_B_W'(k_v));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	ssbsc_mul u_mul (
		.clk (clk),
		.en  (ctl.mul_op != MUL_NONE),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	// highpass: acc += (in - acc) * k, output is in - acc
	assign acc_sum = D_W'(acc_sel) + signed'(psh[D_W-1:0]);
	assign acc_new = sat_acc(acc_sum);
	assign h_new   = H_W'(sel_v) - H_W'(acc_new);

	// ------------------------------------------------------------------
	// slew limiter, shared by the two paths
	// ------------------------------------------------------------------
	logic signed [H_W-1:0]      slew_h;
	logic signed [ACC_BITS-1:0] slew_prev;
	logic [LIM_W-1:0]           lim_v;
	logic signed [D_W-1:0]      lim_s, slew_d, slew_r;
	logic signed [ACC_BITS-1:0] slew_out;
	logic signed [D_W-1:0]      sum_v, sum_sh;
	logic signed [SAMPLE_BITS-1:0] sum_sat;

	assign slew_h    = ctl.slew_bass ? h_b_q : h_t_q;
	assign slew_prev = ctl.slew_bass ? prev_b_q[ctl.ch] : prev_t_q[ctl.ch];
	assign lim_v     = {(ctl.slew_bass ? bass_lim_q : treble_lim_q), {LIM_SHIFT{1'b0}}};
	assign lim_s     = signed'(D_W'(lim_v));
	assign slew_d    = D_W'(slew_h) - D_W'(slew_prev);

	always_comb begin
		if (slew_d > lim_s) begin
			slew_r = D_W'(slew_prev) + lim_s;
		end else if (slew_d < -lim_s) begin
			slew_r = D_W'(slew_prev) - lim_s;
		end else begin
			slew_r = D_W'(slew_h);
		end
	end

	assign slew_out = sat_acc(slew_r);

	// band sum back to Q1.23; treble already slewed in h_t_q
	assign sum_v   = D_W'(h_t_q) + D_W'(slew_out);
	assign sum_sh  = sum_v >>> IN_SHIFT;
	assign sum_sat = sat_smp(sum_sh);

	// ------------------------------------------------------------------
	// state with reset
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			treble_coef_q <= RST_TREBLE_COEF;
			bass_coef_q   <= RST_BASS_COEF;
			treble_lim_q  <= RST_TREBLE_LIMIT;
			bass_lim_q    <= RST_BASS_LIMIT;
			bank_q        <= 1'b1;
			res_valid_q   <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				acc_t_q[i] <= '0;
				acc_b_q[i] <= '0;
			end
			for (int i = 0; i < 2; i++) begin
				prev_t_q[i] <= '0;
				prev_b_q[i] <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_TREBLE_COEF:  treble_coef_q <= cfg_data[COEF_W-1:0];
					CFG_BASS_COEF:    bass_coef_q   <= cfg_data[COEF_W-1:0];
					CFG_TREBLE_LIMIT: treble_lim_q  <= cfg_data[STEP_W-1:0];
					CFG_BASS_LIMIT:   bass_lim_q    <= cfg_data[STEP_W-1:0];
					default: ;
				endcase
			end
			if (ctl.wr_acc) begin
				if (ctl.bass) begin
					acc_b_q[idx] <= acc_new;
				end else begin
					acc_t_q[idx] <= acc_new;
				end
			end
			if (ctl.slew_en) begin
				if (ctl.slew_bass) begin
					prev_b_q[ctl.ch] <= slew_out;
				end else begin
					prev_t_q[ctl.ch] <= slew_out;
				end
			end
			// banks alternate per stereo beat
			if (ctl.fin_right || ctl.hold_right) begin
				bank_q <= ~bank_q;
			end
			if (ctl.fin_right || ctl.push_hold) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			smp_q <= smp;
		end
		if (ctl.wr_acc) begin
			if (ctl.bass) begin
				h_b_q <= h_new;
			end else begin
				h_t_q <= h_new;
			end
		end
		if (ctl.slew_en && !ctl.slew_bass) begin
			h_t_q <= H_W'(slew_out);
		end
		if (ctl.fin_left) begin
			left_res_q <= sum_sat;
		end
		if (ctl.hold_right) begin
			right_res_q <= sum_sat;
		end
		if (ctl.fin_right) begin
			res_q.left_out  <= left_res_q;
			res_q.right_out <= sum_sat;
		end else if (ctl.push_hold) begin
			res_q.left_out  <= left_res_q;
			res_q.right_out <= right_res_q;
		end
	end

endmodule
